// ===== sv/sbmq_pkg.sv =====
// Package for the shared-buffer multi-queue unit.
// Holds request and status codes and the fixed field widths; no dependencies.
`default_nettype none

package sbmq_pkg;

    localparam int KEY_W    = 32;
    localparam int QID_W    = 5;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== sv/sbmq_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the queue pointer, link and key stores; no package dependencies.
`default_nettype none

module sbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/shared_buffer_multi_queue_unit.sv =====
// Top level of the shared-buffer multi-queue unit: control sequencer and result register.
// Depends on sbmq_pkg and sbmq_ram.
//
// Usage. A request (req_type, queue_id, key_in) enters on the input channel when
// in_valid is high and in_stall is low. An insert appends key_in to the queue
// queue_id; a delete removes the oldest key of that queue and returns it on key_out.
// Every request gives exactly one result (key_out, status) on the output channel,
// in request order. Status reports done, queue empty on delete, or pool full on
// insert; a queue number beyond the configured count reports empty or full.
//
// Timing. The unit works on one request at a time. An insert, or any request that
// fails, reads pointer and free-list link at acceptance; the update and the result
// follow in the execute step once the output register is free. A successful delete
// adds the delete step, as the head entry's key and link can only be read once the
// head pointer has come out of the pointer RAM; the registered RAM reads set these
// steps. A new request is taken in the cycle after the result is registered.
//
// Reset clears all queues and the free list, and the pool is handed out afresh.
// While the receiver stalls, one result waits in the output register and the
// next request is still accepted; it then waits in its last step until the
// output register frees.
`default_nettype none

module shared_buffer_multi_queue_unit
    import sbmq_pkg::*;
#(
    parameter int NUM_QUEUES = 20,
    parameter int POOL_DEPTH = 256
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    req_type,
    input  wire logic        [QID_W-1:0] queue_id,
    input  wire logic signed [KEY_W-1:0] key_in,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed      [KEY_W-1:0] key_out,
    output status_t                      status
);

    localparam int PW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QE_W = (QW > QID_W) ? QW : QID_W;
    localparam int QC_W = QE_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic                    type_reg, type_next;
    logic [QID_W-1:0]        q_reg, q_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [NUM_QUEUES-1:0]   nonempty_reg, nonempty_next;
    logic [PW-1:0]           free_top_reg, free_top_next;
    logic                    free_valid_reg, free_valid_next;
    logic [PW:0]             fresh_reg, fresh_next;
    logic                    out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]        out_key_reg, out_key_next;
    status_t                 out_status_reg, out_status_next;

    logic                    accept;
    logic                    out_free;
    logic [QE_W-1:0]         in_q_ext;
    logic [QE_W-1:0]         q_ext;
    logic [QW-1:0]           q_idx;
    logic                    in_range;
    logic                    q_ne;
    logic                    pool_full;
    logic [PW-1:0]           new_entry;

    logic                    ptr_we, ptr_re;
    logic [QW-1:0]           ptr_raddr;
    logic [2*PW-1:0]         ptr_wdata, ptr_rdata;
    logic [PW-1:0]           head, tail;

    logic                    link_we, link_re;
    logic [PW-1:0]           link_waddr, link_raddr, link_wdata, link_rdata;

    logic                    key_we, key_re;
    logic [KEY_W-1:0]        key_rdata;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_q_ext  = QE_W'(queue_id);
    assign q_ext     = QE_W'(q_reg);
    assign q_idx     = q_ext[QW-1:0];
    assign ptr_raddr = in_q_ext[QW-1:0];
    assign in_range  = QC_W'(q_ext) < QC_W'(NUM_QUEUES);
    assign q_ne      = in_range && nonempty_reg[q_idx];

    assign head = ptr_rdata[2*PW-1:PW];
    assign tail = ptr_rdata[PW-1:0];

    assign pool_full = !free_valid_reg && (fresh_reg == (PW+1)'(POOL_DEPTH));
    assign new_entry = free_valid_reg ? free_top_reg : fresh_reg[PW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        type_next       = type_reg;
        q_next          = q_reg;
        key_next        = key_reg;
        nonempty_next   = nonempty_reg;
        free_top_next   = free_top_reg;
        free_valid_next = free_valid_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;

        ptr_we     = 1'b0;
        ptr_re     = accept;
        ptr_wdata  = ptr_rdata;
        link_we    = 1'b0;
        link_re    = accept;
        link_raddr = (state_reg == S_IDLE) ? free_top_reg : head;
        link_waddr = tail;
        link_wdata = new_entry;
        key_we     = 1'b0;
        key_re     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    type_next  = req_type;
                    q_next     = queue_id;
                    key_next   = $unsigned(key_in);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (type_reg == REQ_DELETE && q_ne)
                begin
                    // Fetch the head entry's key and link for the next step.
                    key_re     = 1'b1;
                    link_re    = 1'b1;
                    state_next = S_DEL;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = '0;
                    state_next     = S_IDLE;
                    if (type_reg == REQ_DELETE)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                    else if (!in_range || pool_full)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        out_status_next = ST_DONE;
                        key_we          = 1'b1;
                        ptr_we          = 1'b1;
                        if (nonempty_reg[q_idx])
                        begin
                            link_we   = 1'b1;
                            ptr_wdata = {head, new_entry};
                        end
                        else
                        begin
                            ptr_wdata = {new_entry, new_entry};
                        end
                        nonempty_next[q_idx] = 1'b1;
                        // The last free-list entry links to itself.
                        if (free_valid_reg)
                        begin
                            if (link_rdata == free_top_reg)
                            begin
                                free_valid_next = 1'b0;
                            end
                            else
                            begin
                                free_top_next = link_rdata;
                            end
                        end
                        else
                        begin
                            fresh_next = fresh_reg + 1'b1;
                        end
                    end
                end
            end
            S_DEL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = key_rdata;
                    out_status_next = ST_DONE;
                    state_next      = S_IDLE;
                    if (head == tail)
                    begin
                        nonempty_next[q_idx] = 1'b0;
                    end
                    else
                    begin
                        ptr_we    = 1'b1;
                        ptr_wdata = {link_rdata, tail};
                    end
                    // Push the released entry onto the free list.
                    link_we         = 1'b1;
                    link_waddr      = head;
                    link_wdata      = free_valid_reg ? free_top_reg : head;
                    free_top_next   = head;
                    free_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nonempty_reg   <= '0;
            free_top_reg   <= '0;
            free_valid_reg <= 1'b0;
            fresh_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nonempty_reg   <= nonempty_next;
            free_top_reg   <= free_top_next;
            free_valid_reg <= free_valid_next;
            fresh_reg      <= fresh_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        q_reg          <= q_next;
        key_reg        <= key_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
    end

    sbmq_ram #(
        .WIDTH (2*PW),
        .DEPTH (NUM_QUEUES),
        .AW    (QW)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (q_idx),
        .wdata (ptr_wdata),
        .re    (ptr_re),
        .raddr (ptr_raddr),
        .rdata (ptr_rdata)
    );

    sbmq_ram #(
        .WIDTH (PW),
        .DEPTH (POOL_DEPTH),
        .AW    (PW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    sbmq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (POOL_DEPTH),
        .AW    (PW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (new_entry),
        .wdata (key_reg),
        .re    (key_re),
        .raddr (head),
        .rdata (key_rdata)
    );

    assign out_valid = out_valid_reg;
    assign key_out   = $signed(out_key_reg);
    assign status    = out_status_reg;

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= (PW+1)'(POOL_DEPTH))
        else $error("fresh entry count exceeds the pool depth");

    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_DONE |-> out_key_reg == '0)
        else $error("failed request returns a non-zero key");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted request did not move to the execute step");

    a_delete_frees: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEL && out_free |=> free_valid_reg && out_valid_reg)
        else $error("completed delete did not release its entry");

endmodule

`default_nettype wire

// ===== dv/tb_shared_buffer_multi_queue_unit.sv =====
// Testbench for shared_buffer_multi_queue_unit: directed rows, then random insert and delete
// traffic, checked request by request against a linked-list model of the shared pool.
// Depends on sbmq_pkg and the unit itself.
`default_nettype none

module tb_shared_buffer_multi_queue_unit
    import sbmq_pkg::*;
();

    localparam int NUM_Q       = 20;
    localparam int POOL        = 256;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 120;
    localparam int QUIET_FROM  = 700;
    localparam int QUIET_TO    = 820;
    localparam int STALL_PCT   = 37;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 10;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        status_t          st;
    } response_t;

    typedef struct packed {
        logic             rt;
        logic [QID_W-1:0] q;
        logic [KEY_W-1:0] key;
        bit               typed;
        logic [KEY_W-1:0] exp_key;
        status_t          exp_st;
    } dir_row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic                    req_type  = REQ_INSERT;
    logic        [QID_W-1:0] queue_id  = '0;
    logic signed [KEY_W-1:0] key_in    = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [KEY_W-1:0] key_out;
    status_t                 status;

    // Model of the pool: per-queue head and tail, entry links, stored keys and free list.
    logic [7:0]       head_of    [NUM_Q];
    logic [7:0]       tail_of    [NUM_Q];
    bit               busy_q     [NUM_Q];
    logic [7:0]       next_entry [POOL];
    logic [KEY_W-1:0] key_store  [POOL];
    logic [7:0]       free_head;
    bit               free_nonempty;
    int unsigned      fresh_used;

    response_t awaited_responses[$];
    int        fail_count   = 0;
    int        results_seen = 0;
    int        idle_cycles  = 0;
    bit        sender_idles = 1'b1;
    bit        hold_done    = 1'b0;

    // Rows with a typed response can be read straight off the behaviour; the rest use the model.
    dir_row_t dir_rows [0:21] = '{
        '{REQ_DELETE, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_INSERT, 5'd31, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_FULL},
        '{REQ_DELETE, 5'd20, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_INSERT, 5'd20, 32'h0000_0005, 1'b1, 32'h0000_0000, ST_FULL},
        '{REQ_INSERT, 5'd0,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
        '{REQ_INSERT, 5'd0,  32'h8000_0000, 1'b1, 32'h0000_0000, ST_DONE},
        '{REQ_INSERT, 5'd19, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
        '{REQ_DELETE, 5'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_DONE},
        '{REQ_DELETE, 5'd0,  32'h1234_5678, 1'b1, 32'h8000_0000, ST_DONE},
        '{REQ_DELETE, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_INSERT, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE},
        '{REQ_INSERT, 5'd0,  32'h0000_0001, 1'b1, 32'h0000_0000, ST_DONE},
        '{REQ_INSERT, 5'd0,  32'h0000_0002, 1'b1, 32'h0000_0000, ST_DONE},
        '{REQ_DELETE, 5'd19, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_DONE},
        '{REQ_DELETE, 5'd19, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_DELETE, 5'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
        '{REQ_INSERT, 5'd10, 32'h5A5A_A5A5, 1'b0, 32'h0000_0000, ST_DONE},
        '{REQ_DELETE, 5'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
        '{REQ_DELETE, 5'd10, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
        '{REQ_DELETE, 5'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
        '{REQ_DELETE, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_INSERT, 5'd21, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, ST_FULL}
    };

    shared_buffer_multi_queue_unit #(
        .NUM_QUEUES (NUM_Q),
        .POOL_DEPTH (POOL)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .queue_id  (queue_id),
        .key_in    (key_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_out   (key_out),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic response_t compute_queue_response(input logic rt,
                                                         input logic [QID_W-1:0] q,
                                                         input logic [KEY_W-1:0] k);
        response_t  r;
        logic [7:0] e;
        r.key = '0;
        r.st  = ST_DONE;
        e     = '0;
        if (q >= NUM_Q)
        begin
            r.st = (rt == REQ_DELETE) ? ST_EMPTY : ST_FULL;
        end
        else if (rt == REQ_INSERT)
        begin
            if (free_nonempty)
            begin
                e = free_head;
                // The last entry of the free list links to itself.
                if (next_entry[e] == e)
                    free_nonempty = 1'b0;
                else
                    free_head = next_entry[e];
            end
            else if (fresh_used < POOL)
            begin
                e = fresh_used[7:0];
                fresh_used++;
            end
            else
            begin
                r.st = ST_FULL;
            end
            if (r.st == ST_DONE)
            begin
                key_store[e] = k;
                if (busy_q[q])
                begin
                    next_entry[tail_of[q]] = e;
                    tail_of[q] = e;
                end
                else
                begin
                    head_of[q] = e;
                    tail_of[q] = e;
                    busy_q[q]  = 1'b1;
                end
            end
        end
        else if (!busy_q[q])
        begin
            r.st = ST_EMPTY;
        end
        else
        begin
            e     = head_of[q];
            r.key = key_store[e];
            if (e == tail_of[q])
                busy_q[q] = 1'b0;
            else
                head_of[q] = next_entry[e];
            next_entry[e] = free_nonempty ? free_head : e;
            free_head     = e;
            free_nonempty = 1'b1;
        end
        return r;
    endfunction

    // Entered and left at a falling edge; the request stays on the port until accepted.
    task automatic issue_request(input logic rt, input logic [QID_W-1:0] q,
                                 input logic [KEY_W-1:0] k, input bit typed,
                                 input response_t typed_resp);
        int        gap;
        response_t predicted;
        gap = 0;
        if (sender_idles)
            while ($urandom_range(99) < STALL_PCT)
                gap++;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = rt;
        queue_id = q;
        key_in   = k;
        do
            @(posedge clk);
        while (in_stall);
        predicted = compute_queue_response(rt, q, k);
        awaited_responses.push_back(typed ? typed_resp : predicted);
        @(negedge clk);
    endtask

    task automatic random_requests(input int count, input int insert_pct);
        logic             rt;
        logic [QID_W-1:0] q;
        logic [KEY_W-1:0] k;
        int               pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                q  = QID_W'($urandom_range(31, NUM_Q));
                rt = 1'($urandom_range(1));
            end
            else
            begin
                // Half of the in-range traffic goes to a few queues so that long lists build up.
                q  = ($urandom_range(1) == 1) ? QID_W'($urandom_range(3))
                                              : QID_W'($urandom_range(NUM_Q - 1));
                rt = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
            end
            case ($urandom_range(9))
                0:       k = 32'h7FFF_FFFF;
                1:       k = 32'h8000_0000;
                default: k = $urandom;
            endcase
            issue_request(rt, q, k, 1'b0, '0);
        end
    endtask

    task automatic wait_for_drain();
        in_valid = 1'b0;
        while (awaited_responses.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, one long hold so that the unit backs up, and a quiet window.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO)
                out_stall = 1'b0;
            else
                out_stall = ($urandom_range(99) < STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (awaited_responses.size() == 0)
            begin
                $display("%0t: result with no request pending: key_out %h status %0d",
                         $time, key_out, status);
                fail_count++;
            end
            else
            begin
                if (key_out !== awaited_responses[0].key)
                begin
                    $display("%0t: key_out mismatch, expected %h, actual %h",
                             $time, awaited_responses[0].key, key_out);
                    fail_count++;
                end
                if (status !== awaited_responses[0].st)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, awaited_responses[0].st, status);
                    fail_count++;
                end
                void'(awaited_responses.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request or result accepted for %0d cycles",
                     $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_Q; i++)
            busy_q[i] = 1'b0;
        free_head     = '0;
        free_nonempty = 1'b0;
        fresh_used    = 0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            issue_request(dir_rows[i].rt, dir_rows[i].q, dir_rows[i].key, dir_rows[i].typed,
                          '{key: dir_rows[i].exp_key, st: dir_rows[i].exp_st});

        random_requests(350, 55);
        wait_for_drain();

        // Insert-heavy, no sender gaps, then gaps: the pool runs out and full responses appear.
        sender_idles = 1'b0;
        random_requests(150, 95);
        sender_idles = 1'b1;
        random_requests(180, 95);
        wait_for_drain();

        // Delete-heavy: the free list grows deep and queues run empty.
        random_requests(260, 10);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
